>>> hdl/pwm_tc_pkg.sv
// Package for the PWM timing calculator: widths, codes and the pipeline beat type.
// No dependencies.
`default_nettype none
package pwm_tc_pkg;
   localparam int NumStages = 28;   // quotient bits per clocks divide
   localparam int PreStages = 17;   // quotient bits per period divide
   localparam logic [12:0] PrescaleLimit = 13'd4096;
   localparam logic [16:0] PeriodLimit   = 17'h10000;
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;
   localparam logic [1:0] MODE_LOW  = 2'd0;
   localparam logic [1:0] MODE_HIGH = 2'd1;
   localparam logic [1:0] MODE_PWM  = 2'd2;
   localparam logic [1:0] CSR_CLOCK = 2'd0;
   localparam logic [1:0] CSR_MINF  = 2'd1;
   localparam logic [1:0] CSR_MAXF  = 2'd2;

   // One beat moving through a restoring-division cell chain.
   typedef struct packed {
      logic        vld;
      logic        err;     // result already decided as an error
      logic [1:0]  status;
      logic [15:0] duty;
      logic [27:0] rem;     // partial remainder
      logic [27:0] num;     // dividend bits still to shift in (MSB first)
      logic [27:0] quo;     // quotient bits so far
      logic [27:0] den;     // divisor
   } beat_type;
endpackage
`default_nettype wire

>>> hdl/pwm_tc_cell.sv
// One restoring-division cell: one quotient bit per cycle, registered.
// Depends on pwm_tc_pkg.
`default_nettype none
module pwm_tc_cell
   import pwm_tc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  beat_type      beat_i,
   output beat_type      beat_o
);
   beat_type beat_ff, beat_in;
   logic [28:0] trial;
   logic [28:0] diff;
   always_comb begin
      beat_in = beat_i;
      trial = {beat_i.rem, beat_i.num[27]};
      diff = trial - {1'b0, beat_i.den};
      beat_in.num = {beat_i.num[26:0], 1'b0};
      if (!diff[28]) begin
         beat_in.rem = diff[27:0];
         beat_in.quo = {beat_i.quo[26:0], 1'b1};
      end else begin
         beat_in.rem = trial[27:0];
         beat_in.quo = {beat_i.quo[26:0], 1'b0};
      end
   end
   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
      if (reset) begin
         beat_ff.vld <= 1'b0;
      end
   end
   assign beat_o = beat_ff;
endmodule
`default_nettype wire

>>> hdl/pwm_timing_calculator_core.sv
// PWM timing calculator top level: range check, two chains of divide cells, compare multiply.
// One request every cycle (busy low).
// Pipeline: 28-cell clocks divide, 17-cell period divide, period check stage, output register.
// Synchronous active-high reset clears valid bits and restores register defaults.
// The receiver cannot stall: each result beat is shown for one cycle only.
// Depends on pwm_tc_pkg and pwm_tc_cell.
`default_nettype none
module pwm_timing_calculator_core
   import pwm_tc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [15:0] req_frequency,
   input  wire logic [15:0] req_duty,
   input  wire logic [15:0] req_pulse_count,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [26:0] csr_wdata,
   output      logic        rsp_valid,
   output      logic [1:0]  rsp_status,
   output      logic [11:0] rsp_prescale_code,
   output      logic [15:0] rsp_period_code,
   output      logic [16:0] rsp_compare_value,
   output      logic [1:0]  rsp_output_mode
);
   logic [26:0] clk_hz_ff;
   logic [15:0] minf_ff, maxf_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= 27'd48000000;
         minf_ff   <= 16'd20;
         maxf_ff   <= 16'd20000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLOCK: clk_hz_ff <= csr_wdata;
            CSR_MINF:  minf_ff   <= csr_wdata[15:0];
            CSR_MAXF:  maxf_ff   <= csr_wdata[15:0];
            default:   ;
         endcase
      end
   end
   assign busy = 1'b0;

   // Entry beat: decide early errors, seed the clocks divide with clock + f/2.
   beat_type a_seed;
   beat_type a_chain [0:NumStages];
   always_comb begin
      a_seed = '0;
      a_seed.vld  = start;
      a_seed.duty = req_duty;
      a_seed.den  = {12'd0, req_frequency};
      a_seed.num  = {1'b0, clk_hz_ff} + {13'd0, req_frequency[15:1]};
      if (req_pulse_count != 16'd0) begin
         a_seed.err = 1'b1;
         a_seed.status = ST_COUNT;
      end else if (req_frequency == 16'd0 || req_frequency < minf_ff ||
                   req_frequency > maxf_ff) begin
         a_seed.err = 1'b1;
         a_seed.status = ST_RANGE;
      end
      if (a_seed.err) a_seed.den = 28'd1;
   end
   assign a_chain[0] = a_seed;
   for (genvar i = 0; i < NumStages; i++) begin : g_a
      pwm_tc_cell u_cell (.clock, .reset, .beat_i(a_chain[i]), .beat_o(a_chain[i+1]));
   end

   // Prescaler is ceil(clocks / 65536), at least 1. The period quotient of
   // (clocks + pre/2) / pre never exceeds 17 bits, so the top 11 dividend bits
   // are already below pre: seed them as the remainder and shift in 17 bits.
   logic [27:0] clocks;
   logic [12:0] pre;
   logic [27:0] pnum;
   beat_type    p_seed;
   beat_type    p_chain [0:PreStages];
   always_comb begin
      clocks = a_chain[NumStages].quo;
      pre = 13'(({1'b0, clocks} + 29'h0FFFF) >> 16);
      if (pre == 13'd0) pre = 13'd1;
      pnum = clocks + {16'd0, pre[12:1]};
      p_seed = a_chain[NumStages];
      p_seed.rem = {17'd0, pnum[27:17]};
      p_seed.num = {pnum[16:0], 11'd0};
      p_seed.quo = '0;
      p_seed.den = {15'd0, pre};
      if (!p_seed.err && pre > PrescaleLimit) begin
         p_seed.err = 1'b1;
         p_seed.status = ST_RANGE;
      end
      // drop the divide on an error beat
      if (p_seed.err) begin
         p_seed.den = 28'd1;
         p_seed.rem = '0;
      end
   end
   assign p_chain[0] = p_seed;
   for (genvar j = 0; j < PreStages; j++) begin : g_p
      pwm_tc_cell u_cell (.clock, .reset, .beat_i(p_chain[j]), .beat_o(p_chain[j+1]));
   end

   // Period check stage; the divisor rides along the chain and gives the prescaler.
   logic [16:0] per;
   logic        s_vld_ff, s_err_ff;
   logic [1:0]  s_status_ff;
   logic [15:0] s_duty_ff;
   logic [16:0] s_per_ff;
   logic [11:0] s_pre_ff;
   assign per = p_chain[PreStages].quo[16:0];
   always_ff @(posedge clock) begin
      s_vld_ff    <= p_chain[PreStages].vld;
      s_duty_ff   <= p_chain[PreStages].duty;
      s_pre_ff    <= p_chain[PreStages].den[11:0] - 12'd1;
      s_per_ff    <= per;
      s_status_ff <= p_chain[PreStages].status;
      s_err_ff    <= p_chain[PreStages].err;
      if (!p_chain[PreStages].err && (per < 17'd2 || per > PeriodLimit)) begin
         s_err_ff    <= 1'b1;
         s_status_ff <= ST_RANGE;
      end
      if (reset) s_vld_ff <= 1'b0;
   end

   logic [32:0] prod;
   logic [16:0] cmp;
   logic [1:0]  mode;
   always_comb begin
      prod = s_per_ff * s_duty_ff + 33'h8000;
      if (s_duty_ff == 16'd0) begin
         cmp = '0; mode = MODE_LOW;
      end else if (s_duty_ff == 16'hFFFF) begin
         cmp = s_per_ff; mode = MODE_HIGH;
      end else begin
         cmp = prod[32:16];
         if (cmp == 17'd0) cmp = 17'd1;
         mode = MODE_PWM;
      end
   end
   always_ff @(posedge clock) begin
      rsp_valid <= s_vld_ff;
      rsp_status <= s_status_ff;
      rsp_prescale_code <= s_err_ff ? 12'd0 : s_pre_ff;
      rsp_period_code   <= s_err_ff ? 16'd0 : 16'(s_per_ff - 17'd1);
      rsp_compare_value <= s_err_ff ? 17'd0 : cmp;
      rsp_output_mode   <= s_err_ff ? MODE_LOW : mode;
      if (reset) rsp_valid <= 1'b0;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_period_code == 16'd0)
      else $error("error beat carries a period");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_output_mode == MODE_HIGH |-> rsp_status == ST_OK)
      else $error("mode set on error beat");
   assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
endmodule
`default_nettype wire

>>> test/pwm_timing_calculator_core_tb.sv
// Testbench for the PWM timing calculator core: directed and random requests,
// register changes between phases, results checked against an in-bench predictor.
// Depends on pwm_tc_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module pwm_timing_calculator_core_tb;
   import pwm_tc_pkg::*;

   localparam int PeriodLimitTb   = 65536;
   localparam int PrescaleLimitTb = 4096;
   localparam int Latency         = 47;
   localparam int CycleLimit      = 400000;

   typedef struct packed {
      logic [15:0] frequency;
      logic [15:0] duty;
      logic [15:0] pulse_count;
   } pwm_req_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] prescale_code;
      logic [15:0] period_code;
      logic [16:0] compare_value;
      logic [1:0]  output_mode;
   } pwm_timing_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_frequency = '0;
   logic [15:0] req_duty = '0;
   logic [15:0] req_pulse_count = '0;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_CLOCK;
   logic [26:0] csr_wdata = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_prescale_code;
   logic [15:0] rsp_period_code;
   logic [16:0] rsp_compare_value;
   logic [1:0]  rsp_output_mode;

   pwm_timing_calculator_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor's copy of the registers.
   logic [26:0] clock_hz_reg;
   logic [15:0] min_freq_reg;
   logic [15:0] max_freq_reg;

   pwm_req_t    pending_reqs[$];
   pwm_timing_t expected_timings[$];
   int          failures = 0;
   int          cycles = 0;
   bit          feeding = 1'b0;

   function automatic pwm_timing_t predict_timing(pwm_req_t r);
      pwm_timing_t t;
      longint unsigned f, clk_per, pre, per, cmp;
      t = '0;
      f = r.frequency;
      if (r.pulse_count != 0) begin
         t.status = ST_COUNT;
         return t;
      end
      if (f == 0 || f < min_freq_reg || f > max_freq_reg) begin
         t.status = ST_RANGE;
         return t;
      end
      clk_per = (clock_hz_reg + f / 2) / f;
      pre = (clk_per + PeriodLimitTb - 1) / PeriodLimitTb;
      if (pre == 0) pre = 1;
      if (pre > PrescaleLimitTb) begin
         t.status = ST_RANGE;
         return t;
      end
      per = (clk_per + pre / 2) / pre;
      if (per < 2 || per > PeriodLimitTb) begin
         t.status = ST_RANGE;
         return t;
      end
      if (r.duty == 0) begin
         cmp = 0;
         t.output_mode = MODE_LOW;
      end else if (r.duty == 16'hffff) begin
         cmp = per;
         t.output_mode = MODE_HIGH;
      end else begin
         cmp = (per * r.duty + 32'h8000) >> 16;
         if (cmp == 0) cmp = 1;
         t.output_mode = MODE_PWM;
      end
      t.status        = ST_OK;
      t.prescale_code = 12'(pre - 1);
      t.period_code   = 16'(per - 1);
      t.compare_value = 17'(cmp);
      return t;
   endfunction

   // Driver: hold each beat until accepted, then draw a random gap length.
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (start && busy) begin
            // hold the beat, it was not taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (feeding && pending_reqs.size() > 0) begin
            pwm_req_t r;
            r = pending_reqs.pop_front();
            req_frequency   <= r.frequency;
            req_duty        <= r.duty;
            req_pulse_count <= r.pulse_count;
            start <= 1'b1;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Predict at acceptance; busy stays low, but honor it anyway.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         expected_timings.push_back(predict_timing({req_frequency, req_duty,
                                                     req_pulse_count}));
   end

   // Monitor: compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         pwm_timing_t got, exp_t;
         got = {rsp_status, rsp_prescale_code, rsp_period_code,
                rsp_compare_value, rsp_output_mode};
         if (expected_timings.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, got);
            failures = failures + 1;
         end else begin
            exp_t = expected_timings.pop_front();
            if (got.status !== exp_t.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_t.status, got.status);
               failures = failures + 1;
            end
            if (got.prescale_code !== exp_t.prescale_code) begin
               $display("%0t: prescale_code expected %0d actual %0d", $time,
                        exp_t.prescale_code, got.prescale_code);
               failures = failures + 1;
            end
            if (got.period_code !== exp_t.period_code) begin
               $display("%0t: period_code expected %0d actual %0d", $time,
                        exp_t.period_code, got.period_code);
               failures = failures + 1;
            end
            if (got.compare_value !== exp_t.compare_value) begin
               $display("%0t: compare_value expected %0d actual %0d", $time,
                        exp_t.compare_value, got.compare_value);
               failures = failures + 1;
            end
            if (got.output_mode !== exp_t.output_mode) begin
               $display("%0t: output_mode expected %0d actual %0d", $time,
                        exp_t.output_mode, got.output_mode);
               failures = failures + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("pwm_timing_calculator_core_tb failed");
         $finish;
      end
   end

   // Write one register at a falling edge; the block must be idle.
   task automatic write_reg(logic [1:0] idx, logic [26:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CLOCK: clock_hz_reg = val;
         CSR_MINF:  min_freq_reg = val[15:0];
         default:   max_freq_reg = val[15:0];
      endcase
   endtask

   // Feed the queue, then drain: wait for every expected beat plus latency.
   task automatic run_phase();
      feeding = 1'b1;
      wait (pending_reqs.size() == 0 && gap_left == 0);
      @(negedge clock);
      feeding = 1'b0;
      @(posedge clock);
      wait (expected_timings.size() == 0);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic pwm_req_t mk(int f, int d, int c);
      pwm_req_t r;
      r.frequency = 16'(f); r.duty = 16'(d); r.pulse_count = 16'(c);
      return r;
   endfunction

   // Mostly valid requests in range, some pulse counts and noise.
   function automatic pwm_req_t rand_req();
      pwm_req_t r;
      int sel;
      sel = $urandom_range(0, 9);
      r.pulse_count = (sel == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
      if (sel <= 1) r.frequency = 16'($urandom);
      else if (min_freq_reg <= max_freq_reg)
         r.frequency = 16'($urandom_range(min_freq_reg, max_freq_reg));
      else r.frequency = 16'($urandom);
      case ($urandom_range(0, 7))
         0: r.duty = 16'd0;
         1: r.duty = 16'hffff;
         2: r.duty = 16'($urandom_range(1, 4));
         default: r.duty = 16'($urandom);
      endcase
      return r;
   endfunction

   task automatic random_phase(int n);
      repeat (n) pending_reqs.push_back(rand_req());
      run_phase();
   endtask

   initial begin
      clock_hz_reg = 27'd48000000;
      min_freq_reg = 16'd20;
      max_freq_reg = 16'd20000;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: defaults, field extremes, every special case.
      pending_reqs.push_back(mk(1000, 32768, 0));
      pending_reqs.push_back(mk(1000, 0, 0));
      pending_reqs.push_back(mk(1000, 65535, 0));
      pending_reqs.push_back(mk(1000, 1, 0));
      pending_reqs.push_back(mk(1000, 0, 1));
      pending_reqs.push_back(mk(0, 100, 65535));
      pending_reqs.push_back(mk(0, 100, 0));
      pending_reqs.push_back(mk(19, 100, 0));
      pending_reqs.push_back(mk(20, 100, 0));
      pending_reqs.push_back(mk(20000, 65534, 0));
      pending_reqs.push_back(mk(20001, 100, 0));
      pending_reqs.push_back(mk(65535, 65535, 0));
      run_phase();

      // Big clock, low frequency: large prescaler and full-duty period of 65536.
      write_reg(CSR_CLOCK, 27'd100000000);
      write_reg(CSR_MINF, 27'd1);
      write_reg(CSR_MAXF, 27'd65535);
      pending_reqs.push_back(mk(1, 65535, 0));
      pending_reqs.push_back(mk(23, 40000, 0));
      pending_reqs.push_back(mk(65535, 65535, 0));
      run_phase();
      write_reg(CSR_CLOCK, 27'd65536);
      pending_reqs.push_back(mk(1, 65535, 0));
      pending_reqs.push_back(mk(2, 65535, 0));
      run_phase();
      write_reg(CSR_CLOCK, 27'd1);
      pending_reqs.push_back(mk(1, 5, 0));
      random_phase(150);

      // Inverted limits: everything out of range.
      write_reg(CSR_MINF, 27'd65535);
      write_reg(CSR_MAXF, 27'd1);
      random_phase(40);

      write_reg(CSR_CLOCK, 27'h7ffffff);
      write_reg(CSR_MINF, 27'd1);
      write_reg(CSR_MAXF, 27'd65535);
      random_phase(250);

      write_reg(CSR_CLOCK, 27'd48000000);
      write_reg(CSR_MINF, 27'd20);
      write_reg(CSR_MAXF, 27'd20000);
      random_phase(300);

      write_reg(CSR_CLOCK, 27'($urandom_range(1000, 100000000)));
      write_reg(CSR_MINF, 27'd1);
      write_reg(CSR_MAXF, 27'd65535);
      random_phase(250);

      write_reg(CSR_CLOCK, 27'd100000000);
      write_reg(CSR_MINF, 27'd1000);
      write_reg(CSR_MAXF, 27'd1000);
      random_phase(40);

      write_reg(CSR_CLOCK, 27'($urandom));
      write_reg(CSR_MINF, 27'($urandom_range(1, 300)));
      write_reg(CSR_MAXF, 27'($urandom_range(300, 65535)));
      random_phase(200);

      if (failures == 0 && expected_timings.size() == 0) begin
         $display("pwm_timing_calculator_core_tb passed");
      end else begin
         $display("pwm_timing_calculator_core_tb failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
